// ===== src/gls_pkg.sv =====
// Package for the gcd/lcm block: item payload types, microcode field codes
// and the microcode program itself. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gls_pkg;

    typedef struct packed {
        logic [31:0] first_value;
        logic [31:0] second_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] gcd_value;
        logic [63:0] lcm_value;
        logic        input_error;
    } t_out_item;

    localparam int PC_W = 3;

    // datapath operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_GCD   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_DINIT = 3'd3;
    localparam logic [2:0] OP_DSTEP = 3'd4;
    localparam logic [2:0] OP_MUL   = 3'd5;
    localparam logic [2:0] OP_OUT   = 3'd6;

    // jump conditions
    localparam logic [2:0] C_NEVER  = 3'd0;
    localparam logic [2:0] C_ALWAYS = 3'd1;
    localparam logic [2:0] C_NSTART = 3'd2;
    localparam logic [2:0] C_ZERO   = 3'd3;
    localparam logic [2:0] C_NEQ    = 3'd4;
    localparam logic [2:0] C_KNZ    = 3'd5;
    localparam logic [2:0] C_NLAST  = 3'd6;

    // step addresses
    localparam logic [PC_W-1:0] S_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] S_CHECK = 3'd1;
    localparam logic [PC_W-1:0] S_GCD   = 3'd2;
    localparam logic [PC_W-1:0] S_SCALE = 3'd3;
    localparam logic [PC_W-1:0] S_DINIT = 3'd4;
    localparam logic [PC_W-1:0] S_DSTEP = 3'd5;
    localparam logic [PC_W-1:0] S_MUL   = 3'd6;
    localparam logic [PC_W-1:0] S_OUT   = 3'd7;

    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic start;
        logic zero;
        logic neq;
        logic k_nz;
        logic not_last;
    } t_status;

    typedef struct packed {
        logic [2:0] op;
        logic       busy;
    } t_ctrl;

    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            S_IDLE:  w = '{op: OP_NOP,   cond: C_NSTART, target: S_IDLE};
            S_CHECK: w = '{op: OP_NOP,   cond: C_ZERO,   target: S_OUT};
            S_GCD:   w = '{op: OP_GCD,   cond: C_NEQ,    target: S_GCD};
            S_SCALE: w = '{op: OP_SCALE, cond: C_KNZ,    target: S_SCALE};
            S_DINIT: w = '{op: OP_DINIT, cond: C_NEVER,  target: S_IDLE};
            S_DSTEP: w = '{op: OP_DSTEP, cond: C_NLAST,  target: S_DSTEP};
            S_MUL:   w = '{op: OP_MUL,   cond: C_NEVER,  target: S_IDLE};
            S_OUT:   w = '{op: OP_OUT,   cond: C_ALWAYS, target: S_IDLE};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS, target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== src/gls_seq.sv =====
// Microcode sequencer: step counter, program table and jump logic.
// Depends on gls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gls_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gls_pkg::t_status i_status,
    output gls_pkg::t_ctrl        o_ctrl
);

    logic [gls_pkg::PC_W-1:0] r_pc;
    logic [gls_pkg::PC_W-1:0] n_pc;
    gls_pkg::t_uword          w;
    logic                     jump;

    always_comb begin
        w = gls_pkg::rom(r_pc);
        case (w.cond)
            gls_pkg::C_NEVER:  jump = 1'b0;
            gls_pkg::C_ALWAYS: jump = 1'b1;
            gls_pkg::C_NSTART: jump = !i_status.start;
            gls_pkg::C_ZERO:   jump = i_status.zero;
            gls_pkg::C_NEQ:    jump = i_status.neq;
            gls_pkg::C_KNZ:    jump = i_status.k_nz;
            gls_pkg::C_NLAST:  jump = i_status.not_last;
            default:           jump = 1'b0;
        endcase
        n_pc = jump ? w.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= gls_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op   = w.op;
    assign o_ctrl.busy = (r_pc != gls_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== src/gcd_lcm_subtractive.sv =====
// Top level of the gcd/lcm block: operand datapath driven by the microcode
// sequencer. Depends on gls_pkg and gls_seq.
`timescale 1ns / 1ps
`default_nettype none
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been produced. The result appears for one cycle with
// o_done high, in the cycle in which busy falls, and cannot be held off, so
// capture it on that cycle. While busy, the block runs the binary gcd steps
// and then restores the power of two common to both operands: each gcd step
// does one shift or one subtract, and every subtract is followed by a shift
// that drops an operand bit; the common power of two is restored one bit per
// cycle, and the exact division a/gcd runs one quotient bit per cycle before
// a single multiply.
// A zero operand skips all of this and returns the error result.
module gcd_lcm_subtractive #(
    parameter int WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire gls_pkg::t_in_item i_item,
    output logic                   busy,
    output logic                   o_done,
    output gls_pkg::t_out_item     o_result
);

    localparam int KW = $clog2(WIDTH);

    gls_pkg::t_status status;
    gls_pkg::t_ctrl   ctrl;

    logic [WIDTH-1:0]   r_a, r_b, r_x, r_y, r_q, r_r;
    logic [KW-1:0]      r_k, r_cnt;
    logic               r_err;
    logic [2*WIDTH-1:0] r_prod;
    logic               r_done;
    gls_pkg::t_out_item r_res;

    logic               accept;
    logic [WIDTH-1:0]   in_a, in_b;
    logic [WIDTH:0]     rem_sh;
    logic               fits;

    gls_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    assign busy   = ctrl.busy;
    assign accept = start && !ctrl.busy;
    assign in_a   = i_item.first_value[WIDTH-1:0];
    assign in_b   = i_item.second_value[WIDTH-1:0];

    assign status.start    = start;
    assign status.zero     = r_err;
    assign status.neq      = (r_x != r_y);
    assign status.k_nz     = (r_k != '0);
    assign status.not_last = (r_cnt != KW'(WIDTH - 1));

    assign rem_sh = {r_r, r_q[WIDTH-1]};
    assign fits   = (rem_sh >= {1'b0, r_x});

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a   <= in_a;
            r_b   <= in_b;
            r_x   <= in_a;
            r_y   <= in_b;
            r_k   <= '0;
            r_err <= (in_a == '0) || (in_b == '0);
        end else begin
            case (ctrl.op)
                gls_pkg::OP_GCD: begin
                    if (r_x != r_y) begin
                        if (!r_x[0] && !r_y[0]) begin
                            r_x <= r_x >> 1;
                            r_y <= r_y >> 1;
                            r_k <= r_k + 1'b1;
                        end else if (!r_x[0]) begin
                            r_x <= r_x >> 1;
                        end else if (!r_y[0]) begin
                            r_y <= r_y >> 1;
                        end else if (r_x > r_y) begin
                            r_x <= r_x - r_y;
                        end else begin
                            r_y <= r_y - r_x;
                        end
                    end
                end
                gls_pkg::OP_SCALE: begin
                    if (r_k != '0) begin
                        r_x <= r_x << 1;
                        r_k <= r_k - 1'b1;
                    end
                end
                gls_pkg::OP_DINIT: begin
                    r_q   <= r_a;
                    r_r   <= '0;
                    r_cnt <= '0;
                end
                gls_pkg::OP_DSTEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_q   <= {r_q[WIDTH-2:0], fits};
                    r_r   <= fits ? WIDTH'(rem_sh - {1'b0, r_x}) : rem_sh[WIDTH-1:0];
                end
                gls_pkg::OP_MUL: begin
                    r_prod <= (2*WIDTH)'(r_q) * (2*WIDTH)'(r_b);
                end
                gls_pkg::OP_OUT: begin
                    r_res.gcd_value   <= r_err ? 32'd0 : 32'(r_x);
                    r_res.lcm_value   <= r_err ? 64'd0 : 64'(r_prod);
                    r_res.input_error <= r_err;
                end
                default: begin
                end
            endcase
        end
    end

    // result strobe, one cycle per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (ctrl.op == gls_pkg::OP_OUT);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire
